[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms for the calendar conversion pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ECAL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecal: implication check failed");

// Event now must have been caused by a request a fixed number of cycles ago.
`define ECAL_ASSERT_PAST(name, cons, ante, n) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cons) |-> $past((ante), (n))) \
        else $error("ecal: pipeline alignment check failed");

`endif

[hw/rtl/ecal_pkg.sv]
// ----------------------------------------------------------------------------
// ecal_pkg
// Widths, field types, calendar constants and the month table.
// ----------------------------------------------------------------------------
package ecal_pkg;

    // Field and intermediate widths
    localparam int SEC_W       = 31;
    localparam int YEAR_W      = 11;
    localparam int MONTH_W     = 4;
    localparam int MDAY_W      = 5;
    localparam int HOUR_W      = 5;
    localparam int MIN_W       = 6;
    localparam int SEC_FIELD_W = 6;
    localparam int WDAY_W      = 3;
    localparam int MINS_W      = 26;
    localparam int HOURS_W     = 20;
    localparam int DAYS_W      = 15;
    localparam int YOFF_W      = 7;
    localparam int REM_W       = 9;

    typedef logic [YEAR_W-1:0]      year_t;
    typedef logic [MONTH_W-1:0]     month_t;
    typedef logic [MDAY_W-1:0]      mday_t;
    typedef logic [HOUR_W-1:0]      hour_t;
    typedef logic [MIN_W-1:0]       min_t;
    typedef logic [SEC_FIELD_W-1:0] sec_t;
    typedef logic [WDAY_W-1:0]      wday_t;
    typedef logic [DAYS_W-1:0]      days_t;
    typedef logic [YOFF_W-1:0]      yoff_t;
    typedef logic [REM_W-1:0]       rem_t;

    // Divisors
    localparam int SECS_PER_MIN   = 60;
    localparam int MINS_PER_HOUR  = 60;
    localparam int HOURS_PER_DAY  = 24;
    localparam int DAYS_PER_YEAR  = 365;
    localparam int DAYS_PER_WEEK  = 7;

    // Epoch: 1970-01-01 was a Thursday
    localparam int EPOCH_YEAR     = 1970;
    localparam int EPOCH_WEEKDAY  = 4;

    // Year offset modulo 4 that marks a leap year (1972 is offset 2)
    localparam logic [1:0] LEAP_PHASE = 2'd2;

    localparam month_t MONTH_JAN       = 4'd1;
    localparam month_t MONTH_FEB       = 4'd2;
    localparam month_t MONTHS_PER_YEAR = 4'd12;

    // Month estimate: floor(rem / 31) as (rem * 265) >> 13, exact for any day
    // of the year (rem <= 365)
    localparam int MONTH_RECIP_W = 9;
    localparam logic [MONTH_RECIP_W-1:0] MONTH_RECIP = 9'd265;
    localparam int MONTH_SHIFT   = 13;

    // Pipeline depths
    localparam int DIV_LATENCY  = 2;
    localparam int DATE_LATENCY = DIV_LATENCY + 3;
    localparam int LATENCY      = 3 * DIV_LATENCY + DATE_LATENCY;

    // Day of year at which month idx+1 starts, non-leap year
    function automatic rem_t month_start(input month_t idx);
        rem_t res;
        case (idx)
            4'd0:    res = 9'h000;
            4'd1:    res = 9'h01F;
            4'd2:    res = 9'h03B;
            4'd3:    res = 9'h05A;
            4'd4:    res = 9'h078;
            4'd5:    res = 9'h097;
            4'd6:    res = 9'h0B5;
            4'd7:    res = 9'h0D4;
            4'd8:    res = 9'h0F3;
            4'd9:    res = 9'h111;
            4'd10:   res = 9'h130;
            4'd11:   res = 9'h14E;
            4'd12:   res = 9'h16D;
            default: res = 9'h000;
        endcase
        return res;
    endfunction

endpackage

[hw/rtl/ecal_cdiv.sv]
// ----------------------------------------------------------------------------
// ecal_cdiv
// Two-stage divider by a constant: reciprocal multiply, then one correction.
// ----------------------------------------------------------------------------
module ecal_cdiv #(
    parameter int XW  = 16,
    parameter int QW  = 16,
    parameter int DIV = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     vld_in,
    input  logic [XW-1:0]            x,
    output logic                     vld_out,
    output logic [QW-1:0]            q,
    output logic [$clog2(DIV)-1:0]   r
);

    localparam int RW = $clog2(DIV);
    // floor(2^XW / DIV): estimate is the true quotient or one below it
    localparam longint unsigned RECIP_L = (64'd1 << XW) / DIV;
    localparam logic [XW-1:0] RECIP = XW'(RECIP_L);
    localparam logic [XW-1:0] DIV_X = XW'(DIV);

    logic                vld1_reg;
    logic [XW-1:0]       x_reg;
    logic [2*XW-1:0]     prod_reg;
    logic [2*XW-1:0]     prod_next;
    logic                vld2_reg;
    logic [QW-1:0]       q_reg;
    logic [QW-1:0]       q_next;
    logic [RW-1:0]       r_reg;
    logic [RW-1:0]       r_next;
    logic [XW-1:0]       q_est;
    logic [XW-1:0]       r_est;
    logic                fix;

    always_comb
    begin
        prod_next = (2*XW)'(x) * (2*XW)'(RECIP);
        q_est     = prod_reg[2*XW-1:XW];
        r_est     = x_reg - q_est * DIV_X;
        fix       = (r_est >= DIV_X);
        q_next    = QW'(q_est + XW'(fix));
        r_next    = fix ? RW'(r_est - DIV_X) : RW'(r_est);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x;
        prod_reg <= prod_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
    end

    assign vld_out = vld2_reg;
    assign q       = q_reg;
    assign r       = r_reg;

endmodule

[hw/rtl/ecal_delay.sv]
// ----------------------------------------------------------------------------
// ecal_delay
// Fixed-depth shift line that keeps a field aligned with the pipeline.
// ----------------------------------------------------------------------------
module ecal_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= d;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

[hw/rtl/ecal_date.sv]
// ----------------------------------------------------------------------------
// ecal_date
// Day count to year, month, day of month and weekday over five stages.
// ----------------------------------------------------------------------------
module ecal_date import ecal_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   vld_in,
    input  days_t  days,
    output logic   vld_out,
    output year_t  year,
    output month_t month,
    output mday_t  day,
    output wday_t  weekday
);

    days_t  days_plus;
    logic   yr_vld;
    yoff_t  yoff_est;
    rem_t   yrem;
    wday_t  wday_div;

    // Stage 3: year correction
    yoff_t  leaps_cur;
    yoff_t  leaps_prev;
    logic   under;
    yoff_t  yoff_fix;
    rem_t   rem_next;
    logic   vld3_reg;
    year_t  year3_reg;
    rem_t   rem3_reg;
    logic   leap3_reg;
    wday_t  wday3_reg;

    // Stage 4: month estimate
    logic [REM_W+MONTH_RECIP_W-1:0] mprod;
    month_t mest_raw;
    month_t mest_next;
    logic   vld4_reg;
    year_t  year4_reg;
    rem_t   rem4_reg;
    logic   leap4_reg;
    wday_t  wday4_reg;
    month_t mest4_reg;

    // Stage 5: month correction and day of month
    rem_t   next_start;
    rem_t   cur_start;
    rem_t   day_a;
    rem_t   day_b;
    logic   adv;
    logic   vld5_reg;
    year_t  year_reg;
    month_t month_reg;
    mday_t  day_reg;
    wday_t  wday_reg;

    assign days_plus = days + DAYS_W'(EPOCH_WEEKDAY);

    ecal_cdiv #(
        .XW  (DAYS_W),
        .QW  (YOFF_W),
        .DIV (DAYS_PER_YEAR)
    ) u_year_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (vld_in),
        .x       (days),
        .vld_out (yr_vld),
        .q       (yoff_est),
        .r       (yrem)
    );

    ecal_cdiv #(
        .XW  (DAYS_W),
        .QW  (DAYS_W),
        .DIV (DAYS_PER_WEEK)
    ) u_wday_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (vld_in),
        .x       (days_plus),
        .vld_out (),
        .q       (),
        .r       (wday_div)
    );

    // yrem = days - 365*off; subtract leap days before that year, and step
    // back one year if the estimate starts after the given day
    always_comb
    begin
        leaps_cur  = (yoff_est + YOFF_W'(1)) >> 2;
        leaps_prev = yoff_est >> 2;
        under      = (REM_W'(leaps_cur) > yrem);
        if (under)
        begin
            yoff_fix = yoff_est - YOFF_W'(1);
            rem_next = yrem + REM_W'(DAYS_PER_YEAR) - REM_W'(leaps_prev);
        end
        else
        begin
            yoff_fix = yoff_est;
            rem_next = yrem - REM_W'(leaps_cur);
        end
    end

    always_comb
    begin
        mprod    = (REM_W+MONTH_RECIP_W)'(rem3_reg) * (REM_W+MONTH_RECIP_W)'(MONTH_RECIP);
        mest_raw = MONTH_W'(mprod >> MONTH_SHIFT) + MONTH_JAN;
        mest_next = (mest_raw > MONTHS_PER_YEAR) ? MONTHS_PER_YEAR : mest_raw;
    end

    // Candidate b: the day already lies in the following month
    always_comb
    begin
        next_start = month_start(mest4_reg)
                   + REM_W'(leap4_reg && (mest4_reg >= MONTH_FEB));
        cur_start  = month_start(mest4_reg - MONTH_JAN)
                   + REM_W'(leap4_reg && (mest4_reg > MONTH_FEB));
        adv        = (mest4_reg < MONTHS_PER_YEAR) && (rem4_reg >= next_start);
        day_a      = rem4_reg - cur_start + REM_W'(1);
        day_b      = rem4_reg - next_start + REM_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else
        begin
            vld3_reg <= yr_vld;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        year3_reg <= YEAR_W'(EPOCH_YEAR) + YEAR_W'(yoff_fix);
        rem3_reg  <= rem_next;
        leap3_reg <= (yoff_fix[1:0] == LEAP_PHASE);
        wday3_reg <= wday_div;

        year4_reg <= year3_reg;
        rem4_reg  <= rem3_reg;
        leap4_reg <= leap3_reg;
        wday4_reg <= wday3_reg;
        mest4_reg <= mest_next;

        year_reg  <= year4_reg;
        month_reg <= adv ? (mest4_reg + MONTH_JAN) : mest4_reg;
        day_reg   <= adv ? MDAY_W'(day_b) : MDAY_W'(day_a);
        wday_reg  <= wday4_reg;
    end

    assign vld_out = vld5_reg;
    assign year    = year_reg;
    assign month   = month_reg;
    assign day     = day_reg;
    assign weekday = wday_reg;

endmodule

[hw/rtl/epoch_seconds_to_calendar_unit.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit: seconds since 1970 to calendar date and time
// Throughput: one request per cycle; set by the fully pipelined divider chain.
// busy is held low: the pipeline never stalls, the receiver cannot hold off.
// Reset clears all stage valid bits at once; no results follow until new requests.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epoch_seconds_to_calendar_unit import ecal_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SEC_W-1:0] epoch_seconds,
    output logic             busy,
    output logic             done,
    output year_t            year,
    output month_t           month,
    output mday_t            day,
    output hour_t            hour,
    output min_t             minute,
    output sec_t             second,
    output wday_t            weekday
);

    // A request enters every cycle that start is high
    logic                accept;

    // Stages 1-2: total minutes and second of minute
    logic                v_min;
    logic [MINS_W-1:0]   mins_total;
    sec_t                sec_raw;

    // Stages 3-4: total hours and minute of hour
    logic                v_hour;
    logic [HOURS_W-1:0]  hours_total;
    min_t                min_raw;

    // Stages 5-6: whole days and hour of day
    logic                v_days;
    days_t               days;
    hour_t               hour_raw;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ecal_cdiv #(
        .XW  (SEC_W),
        .QW  (MINS_W),
        .DIV (SECS_PER_MIN)
    ) u_min_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (accept),
        .x       (epoch_seconds),
        .vld_out (v_min),
        .q       (mins_total),
        .r       (sec_raw)
    );

    ecal_cdiv #(
        .XW  (MINS_W),
        .QW  (HOURS_W),
        .DIV (MINS_PER_HOUR)
    ) u_hour_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (v_min),
        .x       (mins_total),
        .vld_out (v_hour),
        .q       (hours_total),
        .r       (min_raw)
    );

    ecal_cdiv #(
        .XW  (HOURS_W),
        .QW  (DAYS_W),
        .DIV (HOURS_PER_DAY)
    ) u_day_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (v_hour),
        .x       (hours_total),
        .vld_out (v_days),
        .q       (days),
        .r       (hour_raw)
    );

    // Date stages produce year, month, day and weekday plus the done strobe
    ecal_date u_date (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (v_days),
        .days    (days),
        .vld_out (done),
        .year    (year),
        .month   (month),
        .day     (day),
        .weekday (weekday)
    );

    // Hold the time-of-day fields back so they leave with their date
    ecal_delay #(
        .W     (SEC_FIELD_W),
        .DEPTH (LATENCY - DIV_LATENCY)
    ) u_sec_dly (
        .clk (clk),
        .d   (sec_raw),
        .q   (second)
    );

    ecal_delay #(
        .W     (MIN_W),
        .DEPTH (LATENCY - 2 * DIV_LATENCY)
    ) u_min_dly (
        .clk (clk),
        .d   (min_raw),
        .q   (minute)
    );

    ecal_delay #(
        .W     (HOUR_W),
        .DEPTH (DATE_LATENCY)
    ) u_hour_dly (
        .clk (clk),
        .d   (hour_raw),
        .q   (hour)
    );

    // Every result traces back to exactly one request
    `ECAL_ASSERT_PAST(a_done_from_request, done, accept, LATENCY)
    `ECAL_ASSERT_PAST(a_days_from_request, v_days, accept, 3 * DIV_LATENCY)
    `ECAL_ASSERT_IMP(a_date_range, done, (month >= MONTH_JAN) && (month <= MONTHS_PER_YEAR) && (day != '0) && (weekday < WDAY_W'(DAYS_PER_WEEK)))
    `ECAL_ASSERT_IMP(a_time_range, done, (hour < HOUR_W'(HOURS_PER_DAY)) && (minute < MIN_W'(MINS_PER_HOUR)) && (second < SEC_FIELD_W'(SECS_PER_MIN)))

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for epoch_seconds_to_calendar_unit
// Sends counts of seconds since the 1970 epoch into the converter. A directed
// table covers field extremes, leap days, month and year boundaries. A long
// random run follows. Every done strobe is compared field by field, in request
// order, against a typed table date or an independent calendar predictor.
// ----------------------------------------------------------------------------
module tb_top import ecal_pkg::*; ();

    // Date and time of day for one request, in the widths of the result ports
    typedef struct packed {
        year_t  year;
        month_t month;
        mday_t  mday;
        hour_t  hour;
        min_t   minute;
        sec_t   second;
        wday_t  wday;
    } calendar_t;

    // One row of the directed table. Where fixed is set, the expected date
    // is typed into the row; otherwise the predictor supplies it.
    typedef struct {
        logic [SEC_W-1:0] secs;
        bit               fixed;
        calendar_t        value;
    } table_row_t;

    localparam int unsigned SECS_PER_DAY       = 86400;
    localparam int unsigned SECS_PER_HOUR      = 3600;
    localparam int unsigned LEAPS_BEFORE_EPOCH = 477;  // leap days in years 1..1969
    localparam int unsigned LAST_EPOCH_DAY     = 24855; // day of 2^31 - 1 seconds
    localparam int unsigned RANDOM_REQUESTS    = 550;

    // Day of year on which each month begins, ordinary year; entry 12 closes December
    localparam int unsigned MONTH_FIRST_DAY [13] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic [SEC_W-1:0] epoch_seconds;
    logic             busy;
    logic             done;
    year_t            year;
    month_t           month;
    mday_t            day;
    hour_t            hour;
    min_t             minute;
    sec_t             second;
    wday_t            weekday;

    calendar_t  pending_dates [$];   // expected dates, oldest request first
    table_row_t directed_rows [$];
    bit         idle_allowed;
    int         requests_sent;
    int         results_checked;
    int         error_count;

    epoch_seconds_to_calendar_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .epoch_seconds (epoch_seconds),
        .busy          (busy),
        .done          (done),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .weekday       (weekday)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------------

    function automatic bit leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // Whole days from the epoch to January 1 of year yr (yr >= 1970)
    function automatic int unsigned days_before_year(input int unsigned yr);
        int unsigned prev;
        prev = yr - 1;
        return prev / 4 - prev / 100 + prev / 400 - LEAPS_BEFORE_EPOCH
               + 365 * (yr - EPOCH_YEAR);
    endfunction

    function automatic calendar_t predict_calendar(input logic [SEC_W-1:0] secs);
        calendar_t   res;
        int unsigned s;
        int unsigned days;
        int unsigned yr;
        int unsigned first;
        int unsigned rem;
        int unsigned mon;
        int unsigned adj;
        bit          leap;
        s    = secs;
        days = s / SECS_PER_DAY;
        // Estimate the year from 365-day years; leap days can push it one too far
        yr    = days / DAYS_PER_YEAR + EPOCH_YEAR;
        first = days_before_year(yr);
        if (first > days)
        begin
            yr    = yr - 1;
            first = days_before_year(yr);
        end
        rem  = days - first;
        leap = leap_year(yr);
        // Estimate the month from 31-day months, then step up at most once
        mon = rem / 31 + 1;
        if (mon > 12)
            mon = 12;
        adj = (leap && mon + 1 > 2) ? 1 : 0;
        if (mon < 12 && rem >= MONTH_FIRST_DAY[mon] + adj)
            mon = mon + 1;
        adj = (leap && mon > 2) ? 1 : 0;
        res.year   = year_t'(yr);
        res.month  = month_t'(mon);
        res.mday   = mday_t'(rem - (MONTH_FIRST_DAY[mon - 1] + adj) + 1);
        res.hour   = hour_t'((s / SECS_PER_HOUR) % HOURS_PER_DAY);
        res.minute = min_t'((s / SECS_PER_MIN) % MINS_PER_HOUR);
        res.second = sec_t'(s % SECS_PER_MIN);
        res.wday   = wday_t'((days + EPOCH_WEEKDAY) % DAYS_PER_WEEK);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------

    task automatic add_fixed_row(input logic [SEC_W-1:0] secs, input int unsigned yr,
                                 input int unsigned mon, input int unsigned md,
                                 input int unsigned hr, input int unsigned mi,
                                 input int unsigned sc, input int unsigned wd);
        table_row_t row;
        row.secs         = secs;
        row.fixed        = 1'b1;
        row.value.year   = year_t'(yr);
        row.value.month  = month_t'(mon);
        row.value.mday   = mday_t'(md);
        row.value.hour   = hour_t'(hr);
        row.value.minute = min_t'(mi);
        row.value.second = sec_t'(sc);
        row.value.wday   = wday_t'(wd);
        directed_rows.push_back(row);
    endtask

    task automatic add_predicted_row(input logic [SEC_W-1:0] secs);
        table_row_t row;
        row.secs  = secs;
        row.fixed = 1'b0;
        row.value = '0;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------------

    // Mix uniform values with values clustered round day, month and year
    // boundaries, where the year and month corrections come into play.
    function automatic logic [SEC_W-1:0] pick_random_seconds();
        int unsigned kind;
        int unsigned yr;
        int unsigned mon;
        int unsigned edge_day;
        logic [31:0] raw;
        longint      cand;
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            raw  = $urandom;
            cand = raw[SEC_W-1:0];
        end
        else if (kind < 55)
        begin
            // last or first seconds of a day
            cand = longint'($urandom_range(0, LAST_EPOCH_DAY)) * SECS_PER_DAY;
            if ($urandom_range(0, 1) == 1)
                cand = cand + SECS_PER_DAY - 1 - $urandom_range(0, 90);
            else
                cand = cand + $urandom_range(0, 90);
        end
        else if (kind < 75)
        begin
            // a couple of days either side of New Year
            yr   = $urandom_range(EPOCH_YEAR, 2038);
            cand = longint'(days_before_year(yr)) * SECS_PER_DAY
                   - 2 * SECS_PER_DAY + $urandom_range(0, 4 * SECS_PER_DAY);
        end
        else
        begin
            // the last and first day of neighbouring months, leap years half the time
            if ($urandom_range(0, 1) == 1)
                yr = 1972 + 4 * $urandom_range(0, 16);
            else
                yr = $urandom_range(EPOCH_YEAR, 2037);
            mon      = $urandom_range(1, 11);
            edge_day = days_before_year(yr) + MONTH_FIRST_DAY[mon]
                       + ((leap_year(yr) && mon >= 2) ? 1 : 0);
            cand     = longint'(edge_day - 1 + $urandom_range(0, 1)) * SECS_PER_DAY
                       + $urandom_range(0, SECS_PER_DAY - 1);
        end
        // keep within the 31-bit input range
        if (cand < 0)
            cand = $urandom_range(0, SECS_PER_DAY - 1);
        if (cand > 64'h7FFF_FFFF)
            cand = 64'h7FFF_FFFF - $urandom_range(0, 3 * SECS_PER_DAY);
        return cand[SEC_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------

    // Idle now and then, present the request, hold it until accepted,
    // then queue its expected date.
    task automatic issue_request(input logic [SEC_W-1:0] secs, input calendar_t want);
        int unsigned gap;
        logic [31:0] noise;
        if (idle_allowed && $urandom_range(0, 99) < 4)
        begin
            gap = $urandom_range(1, 2);
            repeat (gap)
            begin
                // drive junk on the data lines while start is low
                noise = $urandom;
                start         <= 1'b0;
                epoch_seconds <= noise[SEC_W-1:0];
                @(posedge clk);
            end
        end
        start         <= 1'b1;
        epoch_seconds <= secs;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_dates.push_back(want);
        requests_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------

    task automatic check_field(input string label, input logic [YEAR_W-1:0] want,
                               input logic [YEAR_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            error_count++;
        end
    endtask

    // Outputs are sampled at the rising edge that closes the done cycle,
    // before any update scheduled at that edge.
    always @(posedge clk)
    begin : result_check
        calendar_t want;
        if (rst_n && done)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t ns: result with no request outstanding, got %0d-%0d-%0d",
                         $time, year, month, day);
                error_count++;
            end
            else
            begin
                want = pending_dates.pop_front();
                check_field("year",    YEAR_W'(want.year),   YEAR_W'(year));
                check_field("month",   YEAR_W'(want.month),  YEAR_W'(month));
                check_field("day",     YEAR_W'(want.mday),   YEAR_W'(day));
                check_field("hour",    YEAR_W'(want.hour),   YEAR_W'(hour));
                check_field("minute",  YEAR_W'(want.minute), YEAR_W'(minute));
                check_field("second",  YEAR_W'(want.second), YEAR_W'(second));
                check_field("weekday", YEAR_W'(want.wday),   YEAR_W'(weekday));
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin : stimulus
        logic [SEC_W-1:0] secs;
        int               n;
        // initialise every input before the first edge
        start         = 1'b0;
        epoch_seconds = '0;
        rst_n         = 1'b0;
        idle_allowed  = 1'b1;

        // Directed table: field extremes and boundary cases. Typed rows are
        // the epoch itself, the top of the input range and the simple
        // rollovers of seconds, minutes, hours and the first day.
        add_fixed_row(31'd0,          1970, 1,  1,  0,  0,  0, 4);
        add_fixed_row(31'd59,         1970, 1,  1,  0,  0, 59, 4);
        add_fixed_row(31'd60,         1970, 1,  1,  0,  1,  0, 4);
        add_fixed_row(31'd3599,       1970, 1,  1,  0, 59, 59, 4);
        add_fixed_row(31'd3600,       1970, 1,  1,  1,  0,  0, 4);
        add_fixed_row(31'd86399,      1970, 1,  1, 23, 59, 59, 4);
        add_fixed_row(31'd86400,      1970, 1,  2,  0,  0,  0, 5);
        add_fixed_row(31'h7FFF_FFFF,  2038, 1, 19,  3, 14,  7, 2);
        // end of January, end of February in an ordinary year
        add_predicted_row(31'd2592000);
        add_predicted_row(31'd2678400);
        add_predicted_row(31'd5011200);
        add_predicted_row(31'd5097600);
        // first year boundary
        add_predicted_row(31'd31535999);
        add_predicted_row(31'd31536000);
        // leap day and New Year of the first leap year
        add_predicted_row(31'd68169600);
        add_predicted_row(31'd68256000);
        add_predicted_row(31'd94694399);
        add_predicted_row(31'd94694400);
        // century leap year: leap day and the last second of the year
        add_predicted_row(31'd951782400);
        add_predicted_row(31'd951868800);
        add_predicted_row(31'd978307199);
        // last day of 2037, where the year estimate overshoots by one
        add_predicted_row(31'd2145830400);
        // alternating and single high bits
        add_predicted_row(31'h4000_0000);
        add_predicted_row(31'h5555_5555);
        add_predicted_row(31'h2AAA_AAAA);

        // hold reset low, then release it once
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].fixed)
                issue_request(directed_rows[i].secs, directed_rows[i].value);
            else
                issue_request(directed_rows[i].secs, predict_calendar(directed_rows[i].secs));
        end
        n = requests_sent;

        // random part; no idling through the middle stretch
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            idle_allowed = !(i >= 200 && i < 350);
            secs = pick_random_seconds();
            issue_request(secs, predict_calendar(secs));
        end
        start <= 1'b0;

        // drain the pipeline, then watch a little longer for stray strobes
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4)
            @(posedge clk);

        $display("Converted %0d requests (%0d from the table, %0d random) across 1970..2038,",
                 requests_sent, n, requests_sent - n);
        $display("with leap days and month/year edges; %0d results compared, %0d errors.",
                 results_checked, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
